>>> rtl/sha_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and round-constant table for the SHA-256 engine.
// No dependencies; imported by sha_front, sha_back and the top level.
package sha_pkg;

    localparam int SHA_QUEUE_DEPTH = 2;

    localparam logic [31:0] PAD_WORD    = 32'h8000_0000;
    localparam logic [3:0]  LENGTH_SLOT = 4'd14;
    localparam logic [5:0]  LAST_ROUND  = 6'd63;
    localparam logic [2:0]  LAST_INDEX  = 3'd7;
    localparam logic [2:0]  FULL_BYTES  = 3'd4;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    typedef enum logic [1:0] {
        K_DATA,
        K_LAST_FULL,
        K_LAST_PART
    } t_kind;

    typedef struct packed {
        logic [31:0] word;
        t_kind       kind;
        logic [2:0]  nbytes;
    } t_q_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_back_state;

    typedef enum logic [1:0] {
        P_MARK,
        P_FILL,
        P_LEN_LO,
        P_DONE
    } t_pad_step;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
            6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
            6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
            6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
            6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7;  6'd63: k = 32'hC67178F2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/sha_front.sv
`timescale 1ns / 1ps
// Front end: accepts message words, classifies them and applies the pad byte.
// Holds the short item queue toward sha_back. Depends on sha_pkg.
module sha_front
    import sha_pkg::*;
#(
    parameter int QUEUE_DEPTH = SHA_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_msg_word,
    input  logic [2:0]  i_word_bytes,
    input  logic        i_last_word,
    output logic        o_q_valid,
    input  logic        i_q_ready,
    output t_q_item     o_q_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_q_item          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    t_q_item    item;
    logic [2:0] nb;
    logic       push;
    logic       pop;

    // Classify: short counts only matter on the last word, counts above four are full.
    always_comb begin
        nb = (i_last_word && (i_word_bytes < FULL_BYTES)) ? i_word_bytes : FULL_BYTES;
        item.nbytes = nb;
        item.word   = i_msg_word;
        if (!i_last_word) begin
            item.kind = K_DATA;
        end else if (nb == FULL_BYTES) begin
            item.kind = K_LAST_FULL;
        end else begin
            item.kind = K_LAST_PART;
            case (nb)
                3'd0:    item.word = PAD_WORD;
                3'd1:    item.word = {i_msg_word[31:24], 24'h80_0000};
                3'd2:    item.word = {i_msg_word[31:16], 16'h8000};
                3'd3:    item.word = {i_msg_word[31:8], 8'h80};
                default: item.word = i_msg_word;
            endcase
        end
    end

    assign o_ready   = (r_count != CNT_FULL);
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rd_ptr];
    assign push      = i_valid && o_ready;
    assign pop       = o_q_valid && i_q_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item;
        end
    end

endmodule

>>> rtl/sha_back.sv
`timescale 1ns / 1ps
// Back end: schedule window, round datapath, chaining words, length padding
// and digest output sequencer. Depends on sha_pkg.
module sha_back
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_ready,
    input  t_q_item     i_q_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_digest
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    t_back_state r_state, n_state;
    t_pad_step   r_pad_step, n_pad_step;
    logic        r_pad_pending, n_pad_pending;
    logic [3:0]  r_fill, n_fill;
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_out_idx, n_out_idx;
    logic [63:0] r_bitlen, n_bitlen;
    logic [31:0] r_chain [8];
    logic [31:0] n_chain [8];
    logic [31:0] r_rr [8];
    logic [31:0] n_rr [8];
    logic [31:0] r_win [16];

    logic        push_en;
    logic [31:0] push_data;
    logic [31:0] w_next;
    logic [31:0] t1;
    logic [31:0] t2;

    assign w_next = ssig1(r_win[14]) + r_win[9] + ssig0(r_win[1]) + r_win[0];
    assign t1 = r_rr[7] + bsig1(r_rr[4]) + ((r_rr[4] & r_rr[5]) ^ (~r_rr[4] & r_rr[6]))
              + round_k(r_round) + r_win[0];
    assign t2 = bsig0(r_rr[0])
              + ((r_rr[0] & r_rr[1]) ^ (r_rr[0] & r_rr[2]) ^ (r_rr[1] & r_rr[2]));

    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_chain[r_out_idx];
    assign o_word_index  = r_out_idx;
    assign o_last_digest = (r_out_idx == LAST_INDEX);

    always_comb begin
        n_state       = r_state;
        n_pad_step    = r_pad_step;
        n_pad_pending = r_pad_pending;
        n_fill        = r_fill;
        n_round       = r_round;
        n_out_idx     = r_out_idx;
        n_bitlen      = r_bitlen;
        n_chain       = r_chain;
        n_rr          = r_rr;
        push_en       = 1'b0;
        push_data     = '0;
        o_q_ready     = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    n_bitlen  = r_bitlen + 64'({i_q_item.nbytes, 3'b000});
                    push_en   = 1'b1;
                    push_data = i_q_item.word;
                    case (i_q_item.kind)
                        K_LAST_FULL: begin
                            n_pad_pending = 1'b1;
                            n_pad_step    = P_MARK;
                            n_state       = S_PAD;
                        end
                        K_LAST_PART: begin
                            n_pad_pending = 1'b1;
                            n_pad_step    = P_FILL;
                            n_state       = S_PAD;
                        end
                        default: ;
                    endcase
                end
            end
            S_PAD: begin
                push_en = 1'b1;
                case (r_pad_step)
                    P_MARK: begin
                        push_data  = PAD_WORD;
                        n_pad_step = P_FILL;
                    end
                    P_FILL: begin
                        // zero fill up to the length slot, then the high length word
                        if (r_fill == LENGTH_SLOT) begin
                            push_data  = r_bitlen[63:32];
                            n_pad_step = P_LEN_LO;
                        end
                    end
                    P_LEN_LO: begin
                        push_data  = r_bitlen[31:0];
                        n_pad_step = P_DONE;
                    end
                    default: begin
                        push_en = 1'b0;
                        n_state = S_OUT;
                    end
                endcase
            end
            S_ROUND: begin
                n_rr[7] = r_rr[6];
                n_rr[6] = r_rr[5];
                n_rr[5] = r_rr[4];
                n_rr[4] = r_rr[3] + t1;
                n_rr[3] = r_rr[2];
                n_rr[2] = r_rr[1];
                n_rr[1] = r_rr[0];
                n_rr[0] = t1 + t2;
                n_round = r_round + 1'b1;
                if (r_round == LAST_ROUND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + r_rr[i];
                end
                if (!r_pad_pending) begin
                    n_state = S_IDLE;
                end else if (r_pad_step == P_DONE) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_out_idx = r_out_idx + 1'b1;
                    if (r_out_idx == LAST_INDEX) begin
                        // restore initial values for the next message
                        n_chain       = INIT_H;
                        n_bitlen      = '0;
                        n_pad_pending = 1'b0;
                        n_pad_step    = P_MARK;
                        n_state       = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // A push that completes a block starts compression.
        if (push_en) begin
            n_fill = r_fill + 1'b1;
            if (r_fill == 4'hF) begin
                n_rr    = r_chain;
                n_state = S_ROUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pad_step    <= P_MARK;
            r_pad_pending <= 1'b0;
            r_fill        <= '0;
            r_round       <= '0;
            r_out_idx     <= '0;
            r_bitlen      <= '0;
            r_chain       <= INIT_H;
            r_rr          <= '{default: '0};
        end else begin
            r_state       <= n_state;
            r_pad_step    <= n_pad_step;
            r_pad_pending <= n_pad_pending;
            r_fill        <= n_fill;
            r_round       <= n_round;
            r_out_idx     <= n_out_idx;
            r_bitlen      <= n_bitlen;
            r_chain       <= n_chain;
            r_rr          <= n_rr;
        end
    end

    // Schedule window: shift in message words, then extend it one word per round.
    always_ff @(posedge i_clk) begin
        if (push_en || (r_state == S_ROUND)) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= push_en ? push_data : w_next;
        end
    end

    a_round_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ROUND) |-> (r_round == '0))
        else $error("round counter nonzero outside rounds");

    a_fill_round : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND || r_state == S_ADD || r_state == S_OUT) |-> (r_fill == '0))
        else $error("block fill nonzero during compression or output");

    a_idle_nopad : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pad_pending)
        else $error("padding pending while idle");

    a_out_pad : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_pad_pending && r_pad_step == P_DONE))
        else $error("digest output without completed padding");

    a_start_round : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_en && r_fill == 4'hF) |=> (r_state == S_ROUND && r_rr[0] == $past(r_chain[0])))
        else $error("compression did not start from chaining words");

endmodule

>>> rtl/sha256_hash_engine_top.sv
`timescale 1ns / 1ps
// Top level of the SHA-256 engine: front classifier and queue, back compressor.
// Depends on sha_pkg, sha_front and sha_back.
//
//  channel   direction  handshake                payload
//  input     in         i_in_valid / o_in_ready  i_msg_word, i_word_bytes, i_last_word
//  output    out        o_out_valid / i_out_ready o_digest_word, o_word_index, o_last_digest
//
// The back end takes message words one at a time while idle; every sixteenth word starts
// the 64 compression rounds and the chaining add of its 16-word block.
// A last word adds its padding words, one or two compressions and eight digest
// output words. The front queue (QUEUE_DEPTH items) takes words while the back
// end compresses or waits on the output. Reset is synchronous, active low, and
// restores the initial chaining values; no clearing pass is needed.
module sha256_hash_engine_top
    import sha_pkg::*;
#(
    parameter int QUEUE_DEPTH = SHA_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_msg_word,
    input  logic [2:0]  i_word_bytes,
    input  logic        i_last_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_digest
);

    logic    q_valid;
    logic    q_ready;
    t_q_item q_item;

    sha_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_msg_word  (i_msg_word),
        .i_word_bytes(i_word_bytes),
        .i_last_word (i_last_word),
        .o_q_valid   (q_valid),
        .i_q_ready   (q_ready),
        .o_q_item    (q_item)
    );

    sha_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_ready    (q_ready),
        .i_q_item     (q_item),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_digest_word(o_digest_word),
        .o_word_index (o_word_index),
        .o_last_digest(o_last_digest)
    );

endmodule

>>> test/sha256_hash_engine_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for sha256_hash_engine_top: streams messages, predicts each digest.
// Needs sha_pkg and the engine RTL; the SHA-256 predictor is local to this file.
module sha256_hash_engine_top_test;

    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          TARGET_WORDS    = 260;
    localparam logic [2:0]  BYTES_FULL      = 3'd4;
    localparam logic [2:0]  BYTES_NONE      = 3'd0;
    localparam logic [2:0]  BYTES_MAX       = 3'd7;
    localparam logic [31:0] MARK_WORD       = 32'h8000_0000;
    localparam logic [7:0]  MARK_BYTE       = 8'h80;
    localparam int          LEN_HI_SLOT     = 14;
    localparam int          DIGEST_WORDS    = 8;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_entry;

    class sha256_digest_predictor;
        logic [31:0]   chain [8];
        logic [31:0]   sched [16];
        logic [63:0]   msg_bits;
        int unsigned   fill;
        t_digest_entry pending_digest [$];
        int            errors;
        int            words_checked;
        int            messages_hashed;

        static const logic [31:0] START_H [8] = '{
            32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
            32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
        };

        static const logic [31:0] ROUND_K [64] = '{
            32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
            32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
            32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
            32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
            32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
            32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
            32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
            32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
            32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
            32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
            32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
            32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
            32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
            32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
            32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
            32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
        };

        function new();
            errors          = 0;
            words_checked   = 0;
            messages_hashed = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = START_H[i];
            for (int i = 0; i < 16; i++) sched[i] = '0;
            msg_bits = '0;
            fill     = 0;
        endfunction

        function logic [31:0] rotr(logic [31:0] v, int unsigned n);
            return (v >> n) | (v << (32 - n));
        endfunction

        function void compress();
            logic [31:0] r [8];
            logic [31:0] x15, x2, g0, g1, s0, s1, ch, maj, t1, t2;
            for (int i = 0; i < 8; i++) r[i] = chain[i];
            for (int t = 0; t < 64; t++) begin
                // extend the schedule in place over the sixteen-word window
                if (t >= 16) begin
                    x15 = sched[(t + 1) % 16];
                    x2  = sched[(t + 14) % 16];
                    g0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
                    g1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
                    sched[t % 16] = sched[t % 16] + g0 + sched[(t + 9) % 16] + g1;
                end
                s1  = rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25);
                ch  = (r[4] & r[5]) ^ (~r[4] & r[6]);
                t1  = r[7] + s1 + ch + ROUND_K[t] + sched[t % 16];
                s0  = rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22);
                maj = (r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]);
                t2  = s0 + maj;
                r[7] = r[6];
                r[6] = r[5];
                r[5] = r[4];
                r[4] = r[3] + t1;
                r[3] = r[2];
                r[2] = r[1];
                r[1] = r[0];
                r[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] = chain[i] + r[i];
        endfunction

        function void absorb(logic [31:0] w);
            sched[fill] = w;
            fill = (fill + 1) % 16;
            if (fill == 0) compress();
        endfunction

        // Note one accepted input item; a last word queues the eight digest words.
        function void take_word(logic [31:0] word, logic [2:0] nbytes, logic last);
            int unsigned   n;
            logic [31:0]   keep;
            t_digest_entry d;
            n = nbytes;
            if (n > BYTES_FULL || !last) n = BYTES_FULL;
            msg_bits = msg_bits + 64'(n * 8);
            if (!last) begin
                absorb(word);
                return;
            end
            if (n == BYTES_FULL) begin
                absorb(word);
                absorb(MARK_WORD);
            end else begin
                keep = (n == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * n));
                absorb((word & keep) | (32'(MARK_BYTE) << (24 - 8 * n)));
            end
            while (fill != LEN_HI_SLOT) absorb(32'h0);
            absorb(msg_bits[63:32]);
            absorb(msg_bits[31:0]);
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                d = '{chain[i], 3'(i), i == DIGEST_WORDS - 1};
                pending_digest = {pending_digest, d};
            end
            messages_hashed++;
            restart();
        endfunction

        function void check_digest_word(logic [31:0] word, logic [2:0] index, logic last);
            t_digest_entry exp_d;
            if (pending_digest.size() == 0) begin
                $display("%0t: unexpected digest word %08h index %0d last %0b",
                         $time, word, index, last);
                errors++;
                return;
            end
            exp_d = pending_digest.pop_front();
            words_checked++;
            if (word !== exp_d.word) begin
                $display("%0t: digest_word mismatch at index %0d: expected %08h, got %08h",
                         $time, exp_d.index, exp_d.word, word);
                errors++;
            end
            if (index !== exp_d.index) begin
                $display("%0t: word_index mismatch: expected %0d, got %0d",
                         $time, exp_d.index, index);
                errors++;
            end
            if (last !== exp_d.last) begin
                $display("%0t: last_digest mismatch at index %0d: expected %0b, got %0b",
                         $time, exp_d.index, exp_d.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_msg_word;
    logic [2:0]  i_word_bytes;
    logic        i_last_word;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_digest;

    sha256_digest_predictor hasher;
    int unsigned            cycle_count;
    int                     words_sent;
    int                     burst_words;
    bit                     no_idle;

    sha256_hash_engine_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_msg_word    (i_msg_word),
        .i_word_bytes  (i_word_bytes),
        .i_last_word   (i_last_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_digest (o_last_digest)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d digest words still due",
                     cycle_count, hasher.pending_digest.size());
            $display("** sha256_hash_engine_top: FAILED **");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            hasher.check_digest_word(o_digest_word, o_word_index, o_last_digest);
    end

    initial begin
        int gap;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                i_out_ready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance plus any gap.
    task automatic send_word(input logic [31:0] word, input logic [2:0] nbytes,
                             input logic last);
        int gap;
        i_in_valid   = 1'b1;
        i_msg_word   = word;
        i_word_bytes = nbytes;
        i_last_word  = last;
        do @(posedge i_clk); while (!o_in_ready);
        hasher.take_word(word, nbytes, last);
        words_sent++;
        if (no_idle) burst_words++;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_message(input int nwords);
        logic [2:0] nbytes;
        for (int i = 0; i < nwords - 1; i++) begin
            // hold full words mostly; odd byte counts on inner words must be ignored
            nbytes = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : BYTES_FULL;
            send_word($urandom, nbytes, 1'b0);
        end
        send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
    endtask

    initial begin
        int r;
        int nwords;
        int msg_no;
        hasher       = new();
        cycle_count  = 0;
        words_sent   = 0;
        burst_words  = 0;
        no_idle      = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_msg_word   = '0;
        i_word_bytes = '0;
        i_last_word  = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty message, then "abc"
        send_word($urandom, BYTES_NONE, 1'b1);
        send_word(32'h6162_6300, 3'd3, 1'b1);
        send_word(32'hFFFF_FFFF, BYTES_FULL, 1'b1);
        // byte counts above four act as four
        send_word(32'h0000_0000, BYTES_MAX, 1'b1);
        send_word(32'hA5A5_A5A5, 3'd5, 1'b1);
        send_word(32'h5A5A_5A5A, 3'd6, 1'b1);
        // short counts on an inner word are ignored
        send_word(32'h0000_0000, BYTES_NONE, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
        send_word(32'h1234_5678, 3'd2, 1'b1);
        // fourteen full words: the length spills into a second block
        no_idle = 1'b1;
        for (int i = 0; i < 13; i++) send_word($urandom, BYTES_FULL, 1'b0);
        send_word($urandom, BYTES_FULL, 1'b1);
        no_idle = 1'b0;

        msg_no = 0;
        while (words_sent < TARGET_WORDS) begin
            r = $urandom_range(0, 9);
            if (r < 4)      nwords = $urandom_range(1, 5);
            else if (r < 7) nwords = $urandom_range(12, 17);
            else if (r < 9) nwords = $urandom_range(6, 11);
            else            nwords = $urandom_range(18, 40);
            no_idle = (msg_no % 5 == 4);
            send_message(nwords);
            msg_no++;
        end
        no_idle    = 1'b0;
        i_in_valid = 1'b0;

        while (hasher.pending_digest.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d message words in %0d messages (%0d without idling) hashed;",
                 words_sent, hasher.messages_hashed, burst_words);
        $display("%0d digest words checked, %0d mismatches.",
                 hasher.words_checked, hasher.errors);
        if (hasher.errors == 0 && hasher.pending_digest.size() == 0) begin
            $display("** sha256_hash_engine_top: PASSED **");
        end else begin
            $display("** sha256_hash_engine_top: FAILED **");
        end
        $finish;
    end

endmodule
